/* src/ppm_pkg.sv */
package ppm_pkg;

  // width of the period and capture counters
  localparam int COUNT_WIDTH = 16;

  // shared divider: dividend holds tps or capture * 360
  localparam int DIV_W  = COUNT_WIDTH + 9;
  localparam int QUOT_W = 9;
  localparam int STEP_W = 4;

  // wide compare width for saturation checks against 16-bit quantities
  localparam int WIDE_W = COUNT_WIDTH + 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [15:0] TPS_RESET = 16'd2000;
  localparam logic [8:0]  FULL_CIRCLE = 9'd360;
  localparam logic [8:0]  HALF_CIRCLE = 9'd180;
  localparam logic [9:0]  DIGIT_OFFSET = 10'd175;
  localparam logic [7:0]  FREQ_MAX = 8'd255;

  // divide by 36 as multiply by 57 and shift by 11, exact for 0..360
  localparam logic [5:0]  DIGIT_RECIP = 6'd57;
  localparam int          DIGIT_SHIFT = 11;

  // quotient bits per division
  localparam logic [STEP_W-1:0] FREQ_STEPS  = 4'd8;
  localparam logic [STEP_W-1:0] PHASE_STEPS = 4'd9;

  // input word codes
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_REF_EDGE = 1'b1;

  typedef struct packed {
    logic op;
    logic probe_level;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  frequency;
    logic [8:0]  phase_degrees;
    logic [3:0]  phase_digit;
    logic [15:0] period_ticks;
    logic        zero_period;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/ppm_divider.sv */
module ppm_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ppm_pkg::div_req_t         req,
  input  logic [ppm_pkg::DIV_W-1:0] dividend,
  input  logic [ppm_pkg::DIV_W-1:0] divisor,
  output ppm_pkg::div_rsp_t         rsp
);

  // restoring shift-subtract divider, one quotient bit per cycle
  // caller guarantees dividend < divisor << steps

  logic [ppm_pkg::DIV_W-1:0]  rem_r;
  logic [ppm_pkg::DIV_W-1:0]  dvs_r;
  logic [ppm_pkg::QUOT_W-1:0] quot_r;
  logic [ppm_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic                       fits;

  assign fits = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= dividend;
        dvs_r  <= divisor << (req.steps - ppm_pkg::STEP_W'(1));
        quot_r <= '0;
        cnt_r  <= req.steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - dvs_r;
        end
        quot_r <= {quot_r[ppm_pkg::QUOT_W-2:0], fits};
        dvs_r  <= dvs_r >> 1;
        cnt_r  <= cnt_r - ppm_pkg::STEP_W'(1);
        if (cnt_r == ppm_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quot_r;

endmodule

/* src/period_phase_meter.sv */
// period and phase meter. reference edges alternately open and close a
// measurement window; each timebase tick in an open window bumps a saturating
// period count, and a rising probe level on a tick captures that count (last one
// wins, a stale capture is kept if the probe never rises). ticks and opening
// edges never raise in_stall. a closing edge keeps in_stall high while
// frequency (8 quotient bits) and phase (9 bits) run one after another
// through the single shift-subtract divider at one bit per cycle, and while
// the output register is loaded. the phase digit comes from a multiply by a
// reciprocal of 36. a division whose result is known to saturate is skipped,
// and a zero period skips both. the result sits in an output register, so ticks
// keep flowing while it waits to be taken; a closing edge that finishes while
// it still waits stalls longer
module period_phase_meter (
  input  logic               clk,
  input  logic               rst_n,
  // input words: ticks and reference edges
  input  logic               in_valid,
  output logic               in_stall,
  input  ppm_pkg::in_word_t  in_data,
  // result words, one per closing edge
  output logic               out_valid,
  input  logic               out_stall,
  output ppm_pkg::out_word_t out_data,
  // ticks_per_second register
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREQ,
    S_PHASE,
    S_OUT
  } state_t;

  state_t state_r;

  logic [15:0]                     tps_r;
  logic                            window_open_r;
  logic [ppm_pkg::COUNT_WIDTH-1:0] period_count_r;
  logic [ppm_pkg::COUNT_WIDTH-1:0] captured_r;
  logic                            last_probe_r;

  // result fields being built
  logic [7:0] freq_r;
  logic [8:0] phase_r;
  logic [3:0] digit_r;
  logic       zero_r;

  // divider request registers
  logic                       div_start_r;
  logic [ppm_pkg::STEP_W-1:0] div_steps_r;
  logic [ppm_pkg::DIV_W-1:0]  div_dividend_r;
  logic [ppm_pkg::DIV_W-1:0]  div_divisor_r;

  logic               out_valid_r;
  ppm_pkg::out_word_t out_data_r;

  ppm_pkg::div_req_t div_req;
  ppm_pkg::div_rsp_t div_rsp;

  logic                            in_acc;
  logic [ppm_pkg::COUNT_WIDTH-1:0] count_nxt;
  logic                            freq_sat;
  logic                            phase_sat;
  logic [ppm_pkg::DIV_W-1:0]       cap_wide;
  logic [ppm_pkg::DIV_W-1:0]       cap_x360;
  logic [8:0]                      phase_val;
  logic [9:0]                      digit_adj;
  logic [15:0]                     digit_prod;
  logic [3:0]                      digit_val;
  logic [ppm_pkg::WIDE_W-1:0]      period_wide;
  logic [15:0]                     period_out;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign count_nxt = (period_count_r == ppm_pkg::COUNT_MAX) ? period_count_r
                   : period_count_r + ppm_pkg::COUNT_WIDTH'(1);

  // tps >= 256 * period  means frequency clips at 255
  assign period_wide = ppm_pkg::WIDE_W'(period_count_r);
  assign freq_sat = (ppm_pkg::WIDE_W'(tps_r[15:8]) >= period_wide);
  // capture >= period means phase clips at a full circle
  assign phase_sat = (captured_r >= period_count_r);

  // capture * 360 as shifts and adds (256 + 64 + 32 + 8)
  assign cap_wide = ppm_pkg::DIV_W'(captured_r);
  assign cap_x360 = (cap_wide << 8) + (cap_wide << 6) + (cap_wide << 5) + (cap_wide << 3);

  // phase feeding the digit: clipped value or the fresh quotient
  assign phase_val = phase_sat ? ppm_pkg::FULL_CIRCLE : div_rsp.quotient;
  assign digit_adj = (phase_val > ppm_pkg::HALF_CIRCLE)
                   ? {1'b0, phase_val} - ppm_pkg::DIGIT_OFFSET
                   : {1'b0, phase_val} + {1'b0, ppm_pkg::HALF_CIRCLE};

  // digit = adjusted phase / 36 by reciprocal multiply
  assign digit_prod = 16'(digit_adj) * 16'(ppm_pkg::DIGIT_RECIP);
  assign digit_val  = digit_prod[ppm_pkg::DIGIT_SHIFT +: 4];

  // period output clips at 16 bits
  assign period_out = (|period_wide[ppm_pkg::WIDE_W-1:16]) ? 16'hFFFF : period_wide[15:0];

  assign div_req.start = div_start_r;
  assign div_req.steps = div_steps_r;

  ppm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend_r),
    .divisor  (div_divisor_r),
    .rsp      (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tps_r          <= ppm_pkg::TPS_RESET;
      window_open_r  <= 1'b0;
      period_count_r <= '0;
      captured_r     <= '0;
      last_probe_r   <= 1'b0;
      div_start_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      div_start_r <= 1'b0;

      if (cfg_wr_en) begin
        tps_r <= cfg_wr_data;
      end

      // result taken downstream
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.op == ppm_pkg::OP_TICK) begin
              if (window_open_r) begin
                period_count_r <= count_nxt;
                if (in_data.probe_level && !last_probe_r) begin
                  captured_r <= count_nxt;
                end
              end
              last_probe_r <= in_data.probe_level;
            end else if (!window_open_r) begin
              // opening edge
              window_open_r  <= 1'b1;
              period_count_r <= '0;
            end else begin
              // closing edge
              window_open_r <= 1'b0;
              if (period_count_r == '0) begin
                zero_r  <= 1'b1;
                freq_r  <= '0;
                phase_r <= '0;
                digit_r <= '0;
                state_r <= S_OUT;
              end else begin
                zero_r <= 1'b0;
                if (!freq_sat) begin
                  div_start_r    <= 1'b1;
                  div_steps_r    <= ppm_pkg::FREQ_STEPS;
                  div_dividend_r <= ppm_pkg::DIV_W'(tps_r);
                  div_divisor_r  <= ppm_pkg::DIV_W'(period_count_r);
                  state_r        <= S_FREQ;
                end else begin
                  freq_r <= ppm_pkg::FREQ_MAX;
                  if (!phase_sat) begin
                    div_start_r    <= 1'b1;
                    div_steps_r    <= ppm_pkg::PHASE_STEPS;
                    div_dividend_r <= cap_x360;
                    div_divisor_r  <= ppm_pkg::DIV_W'(period_count_r);
                    state_r        <= S_PHASE;
                  end else begin
                    phase_r <= ppm_pkg::FULL_CIRCLE;
                    digit_r <= digit_val;
                    state_r <= S_OUT;
                  end
                end
              end
            end
          end
        end

        S_FREQ: begin
          if (div_rsp.done) begin
            freq_r <= div_rsp.quotient[7:0];
            if (!phase_sat) begin
              div_start_r    <= 1'b1;
              div_steps_r    <= ppm_pkg::PHASE_STEPS;
              div_dividend_r <= cap_x360;
              div_divisor_r  <= ppm_pkg::DIV_W'(period_count_r);
              state_r        <= S_PHASE;
            end else begin
              phase_r <= ppm_pkg::FULL_CIRCLE;
              digit_r <= digit_val;
              state_r <= S_OUT;
            end
          end
        end

        S_PHASE: begin
          if (div_rsp.done) begin
            phase_r <= phase_val;
            digit_r <= digit_val;
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          // wait for the output register to be free
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_data_r.frequency       <= freq_r;
            out_data_r.phase_degrees   <= phase_r;
            out_data_r.phase_digit     <= digit_r;
            out_data_r.period_ticks    <= period_out;
            out_data_r.zero_period     <= zero_r;
            state_r                    <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/period_phase_meter_test.sv */
`timescale 1ns / 100ps

module period_phase_meter_test;

  // timing of the run
  localparam int SETTLE_CYCLES = 40;     // idle margin after the last reading
  localparam int QUIET_LIMIT = 20000;    // cycles with no handshake at all
  localparam int HOLD_CYCLES = 800;      // long receiver hold-off
  localparam int PHASE_WORDS = 320;      // random words per register setting

  // arithmetic of the meter
  localparam logic [ppm_pkg::COUNT_WIDTH-1:0] COUNT_SAT = '1;
  localparam logic [31:0] DEG_FULL = 32'd360;
  localparam logic [31:0] DEG_HALF = 32'd180;
  localparam logic [31:0] DIGIT_BIAS = 32'd175;
  localparam logic [31:0] DEG_PER_DIGIT = 32'd36;
  localparam logic [31:0] FREQ_SAT = 32'd255;

  // probe patterns inside one window
  typedef enum int {
    PROBE_RANDOM,
    PROBE_LOW,
    PROBE_HIGH,
    PROBE_ONE_RISE
  } probe_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ppm_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ppm_pkg::out_word_t out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // words waiting to be offered, and readings the meter still owes us
  ppm_pkg::in_word_t  pending_words[$];
  ppm_pkg::out_word_t expected_readings[$];
  int words_queued = 0;
  int words_accepted = 0;
  int readings_seen = 0;
  int err_count = 0;

  // shadow of the meter's register and state
  logic [15:0]                     tps_model = 16'd2000;
  logic                            win_model = 1'b0;
  logic [ppm_pkg::COUNT_WIDTH-1:0] per_model = '0;
  logic [ppm_pkg::COUNT_WIDTH-1:0] cap_model = '0;
  logic                            probe_model = 1'b0;

  // generator view of whether its own edges leave the window open
  bit gen_open = 1'b0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall shaping
  int stall_pct = 0;
  int stall_cycle = 0;
  int hold_left = 0;
  int holds_done = 0;
  int next_hold_at = 25;

  int quiet_cycles = 0;
  bit                 reading_due;
  ppm_pkg::out_word_t reading_new;
  ppm_pkg::out_word_t reading_want;
  logic [15:0] tps_plan[5];

  period_phase_meter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one line per mismatch
  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, wanted %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // advance the shadow meter by one word; a closing edge yields a reading
  task automatic predict_reading(input ppm_pkg::in_word_t w, output bit emitted,
                                 output ppm_pkg::out_word_t r);
    logic [31:0] freq;
    logic [31:0] phase;
    logic [31:0] digit;
    r = '0;
    emitted = 1'b0;
    if (w.op == ppm_pkg::OP_TICK) begin
      // probe history follows every tick, counting only inside the window
      if (win_model) begin
        if (per_model != COUNT_SAT) per_model = per_model + 1'b1;
        if (w.probe_level && !probe_model) cap_model = per_model;
      end
      probe_model = w.probe_level;
    end else if (!win_model) begin
      // opening edge keeps the old capture
      win_model = 1'b1;
      per_model = '0;
    end else begin
      win_model = 1'b0;
      emitted = 1'b1;
      if (per_model == '0) begin
        r.zero_period = 1'b1;
      end else begin
        freq = 32'(tps_model) / 32'(per_model);
        // wide product, a stale capture can push this past a full turn
        phase = (32'(cap_model) * DEG_FULL) / 32'(per_model);
        if (freq > FREQ_SAT) freq = FREQ_SAT;
        if (phase > DEG_FULL) phase = DEG_FULL;
        if (phase > DEG_HALF) digit = (phase - DIGIT_BIAS) / DEG_PER_DIGIT;
        else digit = (phase + DEG_HALF) / DEG_PER_DIGIT;
        r.frequency = freq[7:0];
        r.phase_degrees = phase[8:0];
        r.phase_digit = digit[3:0];
        r.period_ticks = 16'(per_model);
      end
    end
  endtask

  task automatic queue_word(input logic op, input logic probe);
    ppm_pkg::in_word_t w;
    w.op = op;
    w.probe_level = probe;
    pending_words.push_back(w);
    words_queued++;
    if (op == ppm_pkg::OP_REF_EDGE) gen_open = !gen_open;
  endtask

  // closes any open window, then one window: opening edge, ticks, closing edge
  task automatic queue_window(input int ticks, input probe_mode_t mode);
    int rise_at;
    logic lvl;
    if (gen_open) queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    rise_at = (ticks > 0) ? $urandom_range(ticks - 1) : 0;
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    for (int i = 0; i < ticks; i++) begin
      case (mode)
        PROBE_LOW:      lvl = 1'b0;
        PROBE_HIGH:     lvl = 1'b1;
        PROBE_ONE_RISE: lvl = (i >= rise_at);
        default:        lvl = 1'($urandom_range(1));
      endcase
      queue_word(ppm_pkg::OP_TICK, lvl);
    end
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
  endtask

  // mostly short windows with random content, some noise in between
  task automatic queue_random_phase(input int n_words);
    int start;
    int pick;
    int len;
    start = words_queued;
    while (words_queued - start < n_words) begin
      if ($urandom_range(9) == 0) begin
        // loose ticks and stray edges, window parity gets shuffled too
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          queue_word(($urandom_range(5) == 0) ? ppm_pkg::OP_REF_EDGE : ppm_pkg::OP_TICK,
                     1'($urandom_range(1)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 12) len = 0;
        else if (pick < 90) len = $urandom_range(1, 20);
        else if (pick < 98) len = $urandom_range(21, 60);
        else len = $urandom_range(61, 120);
        queue_window(len, probe_mode_t'($urandom_range(3)));
      end
    end
  endtask

  // block idle: every word taken, every reading back, divider settled
  task automatic wait_drained();
    while (words_accepted != words_queued || expected_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tps(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    tps_model = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender: bursts of random length, random gaps; payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        words_accepted++;
        predict_reading(in_data, reading_due, reading_new);
        if (reading_due) expected_readings.push_back(reading_new);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each reading, stalls on its own changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          flag_mismatch("reading with nothing pending", 1, 0);
        end else begin
          reading_want = expected_readings.pop_front();
          if (out_data.frequency != reading_want.frequency)
            flag_mismatch("frequency", int'(out_data.frequency),
                          int'(reading_want.frequency));
          if (out_data.phase_degrees != reading_want.phase_degrees)
            flag_mismatch("phase_degrees", int'(out_data.phase_degrees),
                          int'(reading_want.phase_degrees));
          if (out_data.phase_digit != reading_want.phase_digit)
            flag_mismatch("phase_digit", int'(out_data.phase_digit),
                          int'(reading_want.phase_digit));
          if (out_data.period_ticks != reading_want.period_ticks)
            flag_mismatch("period_ticks", int'(out_data.period_ticks),
                          int'(reading_want.period_ticks));
          if (out_data.zero_period != reading_want.zero_period)
            flag_mismatch("zero_period", int'(out_data.zero_period),
                          int'(reading_want.zero_period));
        end
      end
      stall_cycle++;
      if (stall_cycle % 256 == 0) begin
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      // long hold-off: output register fills and closing edges back up
      if (hold_left == 0 && holds_done < 2 && readings_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        next_hold_at += 175;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles at %0t", quiet_cycles, $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tps_plan[0] = 16'd1;
    tps_plan[1] = 16'hFFFF;
    tps_plan[2] = 16'd0;
    tps_plan[3] = 16'($urandom_range(2, 65534));
    tps_plan[4] = 16'd2000;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset rate
    // back to back edges: zero period
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    // one tick rising at count one: full turn, frequency saturates
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    queue_word(ppm_pkg::OP_TICK, 1'b1);
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    // ticks with the window closed still track the probe
    queue_word(ppm_pkg::OP_TICK, 1'b0);
    // half period capture: 180 degrees, top digit
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    queue_word(ppm_pkg::OP_TICK, 1'b0);
    queue_word(ppm_pkg::OP_TICK, 1'b1);
    queue_word(ppm_pkg::OP_TICK, 1'b1);
    queue_word(ppm_pkg::OP_TICK, 1'b0);
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    // probe never rises: stale capture
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    queue_word(ppm_pkg::OP_TICK, 1'b0);
    queue_word(ppm_pkg::OP_TICK, 1'b0);
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    // probe high across the open edge is no rise
    queue_word(ppm_pkg::OP_TICK, 1'b1);
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    queue_word(ppm_pkg::OP_TICK, 1'b1);
    queue_word(ppm_pkg::OP_TICK, 1'b1);
    queue_word(ppm_pkg::OP_TICK, 1'b1);
    queue_word(ppm_pkg::OP_REF_EDGE, 1'b0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_tps(tps_plan[p]);
      queue_random_phase(PHASE_WORDS);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
